### design/sprq_pkg.sv
// Shared types, constants and arithmetic helpers for the sprite pixel quad block.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sprq_pkg;

    // Largest sprite side in pixels; larger image sizes clamp to it.
    localparam int MAX_SIDE = 256;
    localparam int SIDE_W   = 9;

    // Trig magnitudes in unsigned Q1.30: one and sqrt(2)/2 rounded to nearest.
    localparam int TRIG_W = 31;
    localparam logic [TRIG_W-1:0] TRIG_ONE        = 31'd1073741824;
    localparam logic [TRIG_W-1:0] TRIG_HALF_SQRT2 = 31'd759250125;

    // Local corner coordinates in units of 2^-17 m.
    localparam int LOC_W  = 27;
    localparam int SUM_W  = LOC_W + 1;
    localparam int PROD_W = SUM_W + TRIG_W + 1;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_PIXEL_WIDTH  = 3'd2,
        CFG_PIXEL_HEIGHT = 3'd3,
        CFG_DIRECTION    = 3'd4,
        CFG_IMAGE_WIDTH  = 3'd5,
        CFG_IMAGE_HEIGHT = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SG_ZERO = 2'b00,
        SG_POS  = 2'b01,
        SG_NEG  = 2'b10
    } t_sign;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [15:0]        pixel_width;
        logic [15:0]        pixel_height;
        logic [2:0]         direction;
        logic [SIDE_W-1:0]  image_width;
        logic [SIDE_W-1:0]  image_height;
    } t_cfg;

    typedef struct packed {
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] vert_a_x;
        logic signed [31:0] vert_a_y;
        logic signed [31:0] vert_b_x;
        logic signed [31:0] vert_b_y;
        logic signed [31:0] vert_c_x;
        logic signed [31:0] vert_c_y;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_opacity;
        logic               last_of_pair;
    } t_tri;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] opacity;
    } t_color;

    // One queued pixel: lower left corner of its square, plus color.
    typedef struct packed {
        logic signed [LOC_W-1:0] lx;
        logic signed [LOC_W-1:0] ly;
        t_color                  color;
    } t_qent;

    // Cosine and sine as sign times a shared magnitude (one or sqrt(2)/2).
    typedef struct packed {
        t_sign kc;
        t_sign ks;
        logic  diag;
    } t_trig;

    function automatic t_trig trig_of(input logic [2:0] dir);
        t_trig t;
        unique case (dir)
            3'd0: t = '{kc: SG_POS,  ks: SG_ZERO, diag: 1'b0};
            3'd1: t = '{kc: SG_POS,  ks: SG_POS,  diag: 1'b1};
            3'd2: t = '{kc: SG_ZERO, ks: SG_POS,  diag: 1'b0};
            3'd3: t = '{kc: SG_NEG,  ks: SG_POS,  diag: 1'b1};
            3'd4: t = '{kc: SG_NEG,  ks: SG_ZERO, diag: 1'b0};
            3'd5: t = '{kc: SG_NEG,  ks: SG_NEG,  diag: 1'b1};
            3'd6: t = '{kc: SG_ZERO, ks: SG_NEG,  diag: 1'b0};
            3'd7: t = '{kc: SG_POS,  ks: SG_NEG,  diag: 1'b1};
        endcase
        return t;
    endfunction

    function automatic logic signed [SUM_W-1:0] sign_term(input t_sign k,
                                                          input logic signed [LOC_W-1:0] v);
        logic signed [SUM_W-1:0] e;
        logic signed [SUM_W-1:0] r;
        e = {v[LOC_W-1], v};
        unique case (k)
            SG_POS:  r = e;
            SG_NEG:  r = -e;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Round a 2^-47 m value to Q16.16 (nearest, ties up), add center, saturate.
    function automatic logic [31:0] place(input logic signed [PROD_W-1:0] v,
                                          input logic signed [31:0] c);
        logic signed [33:0] s;
        logic [31:0]        r;
        s = $signed({{(34 - (PROD_W - 31)){v[PROD_W-1]}}, v[PROD_W-1:31]})
          + $signed({{2{c[31]}}, c})
          + $signed({33'b0, v[30]});
        if (s[33:31] != {3{s[31]}}) begin
            r = s[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/sprq_front.sv
// Front end: takes pixels, drops transparent ones, scales to the local corner.
// Depends on sprq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sprq_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  sprq_pkg::t_cfg       i_cfg,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  sprq_pkg::t_pixel     i_pixel,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output sprq_pkg::t_qent      o_ent
);

    logic                               r_valid;
    sprq_pkg::t_qent                    r_ent;
    logic [sprq_pkg::SIDE_W-1:0]        iw_c;
    logic [sprq_pkg::SIDE_W-1:0]        ih_c;
    logic signed [10:0]                 dx;
    logic signed [10:0]                 dy;
    logic signed [27:0]                 mx;
    logic signed [27:0]                 my;
    sprq_pkg::t_qent                    n_ent;
    logic                               take;

    always_comb begin
        iw_c = (i_cfg.image_width > sprq_pkg::SIDE_W'(sprq_pkg::MAX_SIDE))
             ? sprq_pkg::SIDE_W'(sprq_pkg::MAX_SIDE) : i_cfg.image_width;
        ih_c = (i_cfg.image_height > sprq_pkg::SIDE_W'(sprq_pkg::MAX_SIDE))
             ? sprq_pkg::SIDE_W'(sprq_pkg::MAX_SIDE) : i_cfg.image_height;
        dx = $signed({2'b00, i_pixel.column, 1'b0}) - $signed({2'b00, iw_c});
        dy = $signed({2'b00, i_pixel.row, 1'b0}) - $signed({2'b00, ih_c});
        mx = dx * $signed({1'b0, i_cfg.pixel_width});
        my = dy * $signed({1'b0, i_cfg.pixel_height});
        n_ent.lx            = mx[sprq_pkg::LOC_W-1:0];
        n_ent.ly            = my[sprq_pkg::LOC_W-1:0];
        n_ent.color.red     = i_pixel.red;
        n_ent.color.green   = i_pixel.green;
        n_ent.color.blue    = i_pixel.blue;
        n_ent.color.opacity = i_pixel.opacity;
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_ent   = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            // drop transparent pixels here
            r_valid <= take && (i_pixel.opacity != 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ent <= n_ent;
        end
    end

endmodule

`default_nettype wire

### design/sprq_queue.sv
// Short queue of scaled pixels between the front and back ends.
// Depends on sprq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sprq_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push_valid,
    output logic             o_push_ready,
    input  sprq_pkg::t_qent  i_push_data,
    output logic             o_pop_valid,
    input  wire logic        i_pop_ready,
    output sprq_pkg::t_qent  o_pop_data
);

    sprq_pkg::t_qent                r_mem [sprq_pkg::QDEPTH];
    logic [sprq_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [sprq_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [sprq_pkg::QCNT_W-1:0]    r_count;
    logic                           push;
    logic                           pop;

    assign o_push_ready = (r_count != sprq_pkg::QCNT_W'(sprq_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sprq_pkg::QCNT_W'(sprq_pkg::QDEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count != '0))
        else $error("queue empty after push");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers differ while empty");

endmodule

`default_nettype wire

### design/sprq_back.sv
// Back end: builds corners, rotates, places and emits the two triangles per pixel.
// Depends on sprq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sprq_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  sprq_pkg::t_cfg   i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  sprq_pkg::t_qent  i_ent,
    output logic             o_valid,
    input  wire logic        i_ready,
    output sprq_pkg::t_tri   o_tri
);

    localparam int NC = 4;

    sprq_pkg::t_trig                        trig;
    logic signed [sprq_pkg::LOC_W-1:0]      x0, x1, y0, y1;
    logic signed [sprq_pkg::LOC_W-1:0]      cxs [NC];
    logic signed [sprq_pkg::LOC_W-1:0]      cys [NC];
    logic signed [sprq_pkg::SUM_W-1:0]      n_ux [NC];
    logic signed [sprq_pkg::SUM_W-1:0]      n_uy [NC];
    logic [sprq_pkg::TRIG_W-1:0]            mag;
    logic signed [sprq_pkg::PROD_W-1:0]     n_px [NC];
    logic signed [sprq_pkg::PROD_W-1:0]     n_py [NC];
    logic [31:0]                            n_wx [NC];
    logic [31:0]                            n_wy [NC];

    // stage 1: rotation sums, stage 2: products, stage 3: placed corners
    logic                                   r_v1, r_v2, r_v3, r_half;
    logic signed [sprq_pkg::SUM_W-1:0]      r_ux [NC];
    logic signed [sprq_pkg::SUM_W-1:0]      r_uy [NC];
    logic signed [sprq_pkg::PROD_W-1:0]     r_px [NC];
    logic signed [sprq_pkg::PROD_W-1:0]     r_py [NC];
    logic [31:0]                            r_wx [NC];
    logic [31:0]                            r_wy [NC];
    sprq_pkg::t_color                       r_col1, r_col2, r_col3;

    logic fire, free1, free2, free3;

    always_comb begin
        trig = sprq_pkg::trig_of(i_cfg.direction);
        x0 = i_ent.lx;
        y0 = i_ent.ly;
        x1 = i_ent.lx + $signed({10'b0, i_cfg.pixel_width, 1'b0});
        y1 = i_ent.ly + $signed({10'b0, i_cfg.pixel_height, 1'b0});
        cxs[0] = x0; cys[0] = y0;
        cxs[1] = x1; cys[1] = y0;
        cxs[2] = x1; cys[2] = y1;
        cxs[3] = x0; cys[3] = y1;
        for (int j = 0; j < NC; j++) begin
            n_ux[j] = sprq_pkg::sign_term(trig.kc, cxs[j])
                    - sprq_pkg::sign_term(trig.ks, cys[j]);
            n_uy[j] = sprq_pkg::sign_term(trig.ks, cxs[j])
                    + sprq_pkg::sign_term(trig.kc, cys[j]);
        end
        mag = trig.diag ? sprq_pkg::TRIG_HALF_SQRT2 : sprq_pkg::TRIG_ONE;
        for (int j = 0; j < NC; j++) begin
            n_px[j] = r_ux[j] * $signed({1'b0, mag});
            n_py[j] = r_uy[j] * $signed({1'b0, mag});
            n_wx[j] = sprq_pkg::place(r_px[j], i_cfg.center_x);
            n_wy[j] = sprq_pkg::place(r_py[j], i_cfg.center_y);
        end
    end

    // Stage 3 holds one pixel for two output beats.
    assign fire    = r_v3 && i_ready;
    assign free3   = !r_v3 || (fire && r_half);
    assign free2   = !r_v2 || free3;
    assign free1   = !r_v1 || free2;
    assign o_ready = free1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_half <= 1'b0;
        end else begin
            if (free1) begin
                r_v1 <= i_valid;
            end
            if (free2) begin
                r_v2 <= r_v1;
            end
            if (free3) begin
                r_v3 <= r_v2;
            end
            if (fire) begin
                r_half <= !r_half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1 && i_valid) begin
            r_ux   <= n_ux;
            r_uy   <= n_uy;
            r_col1 <= i_ent.color;
        end
        if (free2 && r_v1) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_col2 <= r_col1;
        end
        if (free3 && r_v2) begin
            r_wx   <= n_wx;
            r_wy   <= n_wy;
            r_col3 <= r_col2;
        end
    end

    always_comb begin
        o_tri.vert_a_x     = r_wx[0];
        o_tri.vert_a_y     = r_wy[0];
        o_tri.vert_b_x     = r_half ? r_wx[2] : r_wx[1];
        o_tri.vert_b_y     = r_half ? r_wy[2] : r_wy[1];
        o_tri.vert_c_x     = r_half ? r_wx[3] : r_wx[2];
        o_tri.vert_c_y     = r_half ? r_wy[3] : r_wy[2];
        o_tri.out_red      = r_col3.red;
        o_tri.out_green    = r_col3.green;
        o_tri.out_blue     = r_col3.blue;
        o_tri.out_opacity  = r_col3.opacity;
        o_tri.last_of_pair = r_half;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> r_v3)
        else $error("second triangle pending without a pixel");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !r_half) |=> (r_v3 && r_half))
        else $error("pixel left before its second triangle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_half) |=> !r_half)
        else $error("pair marker not cleared after second triangle");

endmodule

`default_nettype wire

### design/sprite_pixel_rotated_quad_top.sv
// Top level of the sprite pixel to rotated quad block: configuration registers,
// front end, queue and back end. Depends on sprq_pkg, sprq_front, sprq_queue, sprq_back.
//
// Usage:
//   Pixel channel (i_pix_valid / o_pix_ready / i_pixel): one sprite pixel per beat.
//   A pixel with zero opacity is taken and dropped; any other pixel yields two
//   triangle beats on the result channel (o_tri_valid / i_tri_ready / o_tri):
//   corners 0-1-2 first, then corners 0-2-3 with last_of_pair set.
//   Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   is always ready; write registers only while the block is idle. Indexes
//   beyond the register list are ignored.
//   The first triangle is offered once its pixel has passed the front register,
//   the queue and the back stages for sums, products and placed corners; the second follows once the first is taken.
//   Throughput: while i_tri_ready is high the result port moves one triangle
//   per cycle, and each visible pixel needs two of them; the pixel side takes
//   one beat per cycle until the four-entry queue between front and back fills.
//   A stalled receiver freezes the back pipeline; the queue and the front keep
//   taking pixels until both are full, then o_pix_ready drops.
//   Reset (synchronous, active low) empties the pipeline and the queue and
//   loads the register defaults: center 0, pixel size 524, direction 0,
//   image size 64 by 64.
`timescale 1ns / 1ps
`default_nettype none

module sprite_pixel_rotated_quad_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    input  wire logic         i_pix_valid,
    output logic              o_pix_ready,
    input  sprq_pkg::t_pixel  i_pixel,
    output logic              o_tri_valid,
    input  wire logic         i_tri_ready,
    output sprq_pkg::t_tri    o_tri
);

    sprq_pkg::t_cfg   r_cfg;
    logic             f_valid;
    logic             f_ready;
    sprq_pkg::t_qent  f_ent;
    logic             q_valid;
    logic             q_ready;
    sprq_pkg::t_qent  q_ent;

    // Configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x     <= '0;
            r_cfg.center_y     <= '0;
            r_cfg.pixel_width  <= 16'd524;
            r_cfg.pixel_height <= 16'd524;
            r_cfg.direction    <= '0;
            r_cfg.image_width  <= 9'd64;
            r_cfg.image_height <= 9'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sprq_pkg::CFG_CENTER_X:     r_cfg.center_x     <= i_cfg_data;
                sprq_pkg::CFG_CENTER_Y:     r_cfg.center_y     <= i_cfg_data;
                sprq_pkg::CFG_PIXEL_WIDTH:  r_cfg.pixel_width  <= i_cfg_data[15:0];
                sprq_pkg::CFG_PIXEL_HEIGHT: r_cfg.pixel_height <= i_cfg_data[15:0];
                sprq_pkg::CFG_DIRECTION:    r_cfg.direction    <= i_cfg_data[2:0];
                sprq_pkg::CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[8:0];
                sprq_pkg::CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[8:0];
                default: ; // drop writes past the register list
            endcase
        end
    end

    // Front: accept, drop transparent pixels, scale to the local corner.
    sprq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_pix_valid),
        .o_ready (o_pix_ready),
        .i_pixel (i_pixel),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_ent   (f_ent)
    );

    // Queue: decouple a stalled result side from the pixel side.
    sprq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_ent),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_ent)
    );

    // Back: rotate, place and emit two triangle beats per pixel.
    sprq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_ent   (q_ent),
        .o_valid (o_tri_valid),
        .i_ready (i_tri_ready),
        .o_tri   (o_tri)
    );

endmodule

`default_nettype wire
